>>> rtl/cpbd_pkg.sv
// ----------------------------------------------------------------------------
// cpbd_pkg
// Shared types and constants for the CPU port and bank decoder: target codes,
// register addresses, reset values and the structs passed between modules.
// ----------------------------------------------------------------------------
package cpbd_pkg;

    // Target codes reported with every transaction.
    typedef enum logic [2:0] {
        TGT_PORT   = 3'd0,
        TGT_RAM    = 3'd1,
        TGT_KERNAL = 3'd2,
        TGT_BASIC  = 3'd3,
        TGT_CHAR   = 3'd4,
        TGT_IO     = 3'd5
    } target_t;

    // Configuration register word indexes (byte address bits 3:2).
    localparam logic [1:0] REG_TAPE_SWITCH = 2'd0;
    localparam logic [1:0] REG_CAPS_LOCK   = 2'd1;
    localparam logic [1:0] REG_PULLUPS     = 2'd2;

    // Bank select codes taken from CPU address bits 15:12.
    localparam logic [3:0] BLK_BASIC_LO  = 4'hA;
    localparam logic [3:0] BLK_BASIC_HI  = 4'hB;
    localparam logic [3:0] BLK_IO_CHAR   = 4'hD;
    localparam logic [3:0] BLK_KERNAL_LO = 4'hE;
    localparam logic [3:0] BLK_KERNAL_HI = 4'hF;

    // Reset values.
    localparam logic [7:0] RST_DIRECTION = 8'h00;
    localparam logic [7:0] RST_DATA      = 8'h3F;
    localparam logic [7:0] RST_LATCH     = 8'h3F;
    localparam logic [7:0] RST_PULLUPS   = 8'h17;
    localparam logic       RST_TAPE      = 1'b0;
    localparam logic       RST_CAPS      = 1'b1;

    // Processor port registers.
    typedef struct packed {
        logic [7:0] direction;
        logic [7:0] data;
        logic [7:0] latch;
    } port_state_t;

    // Configuration registers.
    typedef struct packed {
        logic       tape_switch;
        logic       caps_lock;
        logic [7:0] pullups;
    } cfg_t;

    // One result item.
    typedef struct packed {
        target_t    target;
        logic [7:0] read_data;
        logic [7:0] pins_out;
        logic [7:0] direction_out;
    } result_t;

endpackage

>>> rtl/cpbd_port_logic.sv
// ----------------------------------------------------------------------------
// cpbd_port_logic
// Combinational port update and bank decode for one CPU transaction: applies
// a port register write, recomputes latch and readback, and picks the target.
// ----------------------------------------------------------------------------
module cpbd_port_logic
    import cpbd_pkg::*;
(
    input  logic        kind,
    input  logic [15:0] address,
    input  logic [7:0]  write_data,
    input  port_state_t cur,
    input  cfg_t        cfg,
    output port_state_t nxt,
    output result_t     res
);

    logic       is_port;
    logic [7:0] dir;
    logic [7:0] dat;
    logic [7:0] latch;
    logic [7:0] readback;
    logic [2:0] bank_cfg;
    target_t    bank_target;

    assign is_port = (address[15:1] == 15'd0);

    // Port register writes take effect before the readback is formed.
    always_comb
    begin
        dir = cur.direction;
        dat = cur.data;
        if (kind && is_port)
        begin
            if (address[0])
            begin
                dat = write_data;
            end
            else
            begin
                dir = write_data;
            end
        end
    end

    // Output pins follow the data register only where the pin is an output.
    assign latch = (cur.latch & ~dir) | (dat & dir);

    // Data readback with pullups and the sense lines.
    always_comb
    begin
        readback = (dat | ~dir) & (latch | cfg.pullups);
        if (cfg.pullups[6] && !cfg.caps_lock)
        begin
            readback[6] = 1'b0;
        end
        if (!dir[5])
        begin
            readback[5] = 1'b0;
        end
        if (cfg.tape_switch && !dir[4])
        begin
            readback[4] = 1'b0;
        end
    end

    // Bank decode from the three low port lines.
    assign bank_cfg = dat[2:0] | ~dir[2:0];

    always_comb
    begin
        case (address[15:12])
            BLK_BASIC_LO, BLK_BASIC_HI:
                bank_target = (bank_cfg[1:0] == 2'b11) ? TGT_BASIC : TGT_RAM;
            BLK_IO_CHAR:
            begin
                if (bank_cfg > 3'd4)
                begin
                    bank_target = TGT_IO;
                end
                else if (bank_cfg != 3'd0 && bank_cfg != 3'd4)
                begin
                    bank_target = TGT_CHAR;
                end
                else
                begin
                    bank_target = TGT_RAM;
                end
            end
            BLK_KERNAL_LO, BLK_KERNAL_HI:
                bank_target = bank_cfg[1] ? TGT_KERNAL : TGT_RAM;
            default:
                bank_target = TGT_RAM;
        endcase
    end

    // Next port state and the result item.
    always_comb
    begin
        nxt.direction = dir;
        nxt.data      = dat;
        nxt.latch     = latch;

        res.target        = is_port ? TGT_PORT : bank_target;
        res.read_data     = 8'h00;
        res.pins_out      = latch;
        res.direction_out = dir;
        if (is_port && !kind)
        begin
            res.read_data = address[0] ? readback : dir;
        end
    end

endmodule

>>> rtl/cpu_port_and_bank_decoder.sv
// ----------------------------------------------------------------------------
// cpu_port_and_bank_decoder
// Processor I/O port at addresses 0 and 1 plus the memory bank decoder,
// one result transaction per CPU access transaction.
// ----------------------------------------------------------------------------
// Each CPU access goes into an input register, is processed by shallow logic
// on the port registers, and its result lands in an output register; one
// transaction is accepted every cycle when the output side is not stalled.
// The throughput is set by the single update of the port registers per
// cycle. Configuration registers sit at byte addresses 0 (tape switch
// sense), 4 (caps lock sense) and 8 (pullup mask); they must be written
// only while idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module cpu_port_and_bank_decoder
    import cpbd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    // CPU access transactions.
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [15:0] address,
    input  logic [7:0]  write_data,

    // Result transactions.
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  target,
    output logic [7:0]  port_read_data,
    output logic [7:0]  port_pins_out,
    output logic [7:0]  port_direction_out
);

    cfg_t        cfg_reg;
    port_state_t port_reg;
    port_state_t port_next;
    result_t     res_next;
    result_t     res_reg;

    logic        s1_valid_reg;
    logic        s1_kind_reg;
    logic [15:0] s1_address_reg;
    logic [7:0]  s1_write_data_reg;
    logic        out_valid_reg;

    logic        out_free;
    logic        s1_fire;
    logic        in_fire;
    logic        cfg_write;

    // Configuration register access.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tape_switch <= RST_TAPE;
            cfg_reg.caps_lock   <= RST_CAPS;
            cfg_reg.pullups     <= RST_PULLUPS;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_TAPE_SWITCH: cfg_reg.tape_switch <= pwdata[0];
                REG_CAPS_LOCK:   cfg_reg.caps_lock   <= pwdata[0];
                REG_PULLUPS:     cfg_reg.pullups     <= pwdata[7:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_TAPE_SWITCH: prdata = {31'd0, cfg_reg.tape_switch};
            REG_CAPS_LOCK:   prdata = {31'd0, cfg_reg.caps_lock};
            REG_PULLUPS:     prdata = {24'd0, cfg_reg.pullups};
            default:         prdata = 32'd0;
        endcase
    end

    // Pipeline flow control.
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_fire  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_fire  = in_valid && !in_stall;

    // Input register stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_kind_reg       <= kind;
            s1_address_reg    <= address;
            s1_write_data_reg <= write_data;
        end
    end

    // Port update and bank decode.
    cpbd_port_logic u_port_logic (
        .kind       (s1_kind_reg),
        .address    (s1_address_reg),
        .write_data (s1_write_data_reg),
        .cur        (port_reg),
        .cfg        (cfg_reg),
        .nxt        (port_next),
        .res        (res_next)
    );

    // Port registers change once per processed transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            port_reg.direction <= RST_DIRECTION;
            port_reg.data      <= RST_DATA;
            port_reg.latch     <= RST_LATCH;
        end
        else if (s1_fire)
        begin
            port_reg <= port_next;
        end
    end

    // Output register stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid          = out_valid_reg;
    assign target             = res_reg.target;
    assign port_read_data     = res_reg.read_data;
    assign port_pins_out      = res_reg.pins_out;
    assign port_direction_out = res_reg.direction_out;

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for the CPU port and bank decoder. A driver sends CPU access
// transactions in random bursts. A monitor checks every result transaction
// against a predictor of the port registers and the bank decode. The sense
// lines and the pullup mask are changed through the APB port between phases.
// ----------------------------------------------------------------------------
module tb;
    import cpbd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PER_PHASE = 165;
    localparam int PHASE_COUNT = 6;

    // One CPU access waiting to be sent.
    typedef struct {
        logic        is_write;
        logic [15:0] addr;
        logic [7:0]  wdata;
    } cpu_access_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        kind = 1'b0;
    logic [15:0] address = '0;
    logic [7:0]  write_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  target;
    logic [7:0]  port_read_data;
    logic [7:0]  port_pins_out;
    logic [7:0]  port_direction_out;

    // Predicted port and configuration state.
    logic [7:0]  port_dir;
    logic [7:0]  port_data;
    logic [7:0]  port_latch;
    logic        sense_tape;
    logic        sense_caps;
    logic [7:0]  pullup_mask;

    cpu_access_t queued_accesses[$];
    result_t     awaited_decodes[$];
    int          mismatch_count = 0;
    int          burst_left = 1;
    int          gap_left = 0;
    int          stall_mode = 0;
    int          stall_timer = 0;
    int          cycle_count = 0;
    int          idle_cycles = 0;

    cpu_port_and_bank_decoder DUT (
        .clk                (clk),
        .rst_n              (rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .kind               (kind),
        .address            (address),
        .write_data         (write_data),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .target             (target),
        .port_read_data     (port_read_data),
        .port_pins_out      (port_pins_out),
        .port_direction_out (port_direction_out)
    );

    // Clock with a 12 ns period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Applies one access to the predicted port state and returns its result.
    function automatic result_t decode_access(input logic is_write, input logic [15:0] addr,
                                              input logic [7:0] wdata);
        result_t    res;
        logic [7:0] readback;
        logic [2:0] bank_mode;
        begin
            if (is_write && addr == 16'd0)
                port_dir = wdata;
            else if (is_write && addr == 16'd1)
                port_data = wdata;

            // Latch follows data on output pins; readback sees pullups and sense lines.
            port_latch = (port_latch & ~port_dir) | (port_data & port_dir);
            readback = (port_data | ~port_dir) & (port_latch | pullup_mask);
            if (pullup_mask[6] && !sense_caps)
                readback[6] = 1'b0;
            if (!port_dir[5])
                readback[5] = 1'b0;
            if (sense_tape && !port_dir[4])
                readback[4] = 1'b0;

            res.read_data = 8'h00;
            if (addr <= 16'd1)
            begin
                res.target = TGT_PORT;
                if (!is_write)
                    res.read_data = (addr == 16'd0) ? port_dir : readback;
            end
            else
            begin
                // Memory map chosen by the three low port lines.
                bank_mode = port_data[2:0] | ~port_dir[2:0];
                case (addr[15:12])
                    BLK_BASIC_LO, BLK_BASIC_HI:
                        res.target = (bank_mode[1:0] == 2'b11) ? TGT_BASIC : TGT_RAM;
                    BLK_IO_CHAR:
                        if (bank_mode > 3'd4)
                            res.target = TGT_IO;
                        else if (bank_mode != 3'd0 && bank_mode < 3'd4)
                            res.target = TGT_CHAR;
                        else
                            res.target = TGT_RAM;
                    BLK_KERNAL_LO, BLK_KERNAL_HI:
                        res.target = bank_mode[1] ? TGT_KERNAL : TGT_RAM;
                    default:
                        res.target = TGT_RAM;
                endcase
            end
            res.pins_out = port_latch;
            res.direction_out = port_dir;
            return res;
        end
    endfunction

    // Builds a random access, biased toward port writes and the banked regions.
    function automatic cpu_access_t random_access();
        cpu_access_t acc;
        int          pick;
        logic [3:0]  blocks[6];
        begin
            blocks = '{BLK_BASIC_LO, BLK_BASIC_HI, BLK_IO_CHAR, BLK_KERNAL_LO,
                       BLK_KERNAL_HI, 4'h0};
            blocks[5] = 4'($urandom_range(0, 15));
            pick = $urandom_range(0, 99);
            acc.is_write = 1'($urandom_range(0, 1));
            acc.wdata = 8'($urandom_range(0, 255));
            if (pick < 24)
            begin
                acc.is_write = 1'b1;
                acc.addr = (pick < 12) ? 16'd0 : 16'd1;
                if ($urandom_range(0, 3) == 0)
                    acc.wdata = ($urandom_range(0, 1) == 0) ? 8'h2F : 8'hFF;
            end
            else if (pick < 34)
            begin
                acc.is_write = 1'b0;
                acc.addr = 16'($urandom_range(0, 1));
            end
            else if (pick < 84)
                acc.addr = {blocks[$urandom_range(0, 5)], 12'($urandom_range(0, 4095))};
            else
                acc.addr = 16'($urandom_range(0, 65535));
            return acc;
        end
    endfunction

    task automatic push_access(input logic is_write, input logic [15:0] addr,
                               input logic [7:0] wdata);
        cpu_access_t acc;
        begin
            acc.is_write = is_write;
            acc.addr = addr;
            acc.wdata = wdata;
            queued_accesses.push_back(acc);
        end
    endtask

    // APB write: setup cycle, then access cycle until pready.
    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        begin
            @(posedge clk);
            psel <= 1'b1;
            penable <= 1'b0;
            pwrite <= 1'b1;
            paddr <= {idx, 2'b00};
            pwdata <= value;
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            while (!pready)
                @(posedge clk);
            psel <= 1'b0;
            penable <= 1'b0;
            pwrite <= 1'b0;
            case (idx)
                REG_TAPE_SWITCH: sense_tape = value[0];
                REG_CAPS_LOCK:   sense_caps = value[0];
                REG_PULLUPS:     pullup_mask = value[7:0];
                default: ;
            endcase
        end
    endtask

    task automatic set_config(input logic tape, input logic caps, input logic [7:0] pullups);
        begin
            write_register(REG_TAPE_SWITCH, {31'd0, tape});
            write_register(REG_CAPS_LOCK, {31'd0, caps});
            write_register(REG_PULLUPS, {24'd0, pullups});
        end
    endtask

    // Waits until every queued access has been sent and answered.
    task automatic drain();
        begin
            while (queued_accesses.size() != 0 || in_valid || awaited_decodes.size() != 0)
                @(posedge clk);
            repeat (4) @(posedge clk);
        end
    endtask

    // Stimulus sequencing: reset, directed accesses, then random phases.
    initial
    begin
        port_dir = RST_DIRECTION;
        port_data = RST_DATA;
        port_latch = RST_LATCH;
        sense_tape = RST_TAPE;
        sense_caps = RST_CAPS;
        pullup_mask = RST_PULLUPS;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                1: set_config(1'b1, 1'b0, 8'hFF);
                2: set_config(1'b0, 1'b1, 8'h00);
                3: set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              8'($urandom_range(0, 255)));
                4: set_config(1'b1, 1'b0, 8'h40);
                5: set_config(1'b0, 1'b0, 8'($urandom_range(0, 255)));
                default: ;
            endcase
            if (phase == 0)
            begin
                // Reset readback, every bank mode that selects a distinct target,
                // writes that miss the port, and write data on reads that must be ignored.
                push_access(1'b0, 16'h0000, 8'h00);
                push_access(1'b0, 16'h0001, 8'h00);
                push_access(1'b0, 16'hA000, 8'h00);
                push_access(1'b0, 16'hD000, 8'h00);
                push_access(1'b0, 16'hE123, 8'h00);
                push_access(1'b0, 16'hFFFF, 8'h00);
                push_access(1'b0, 16'h0002, 8'h00);
                push_access(1'b1, 16'h0000, 8'hFF);
                push_access(1'b1, 16'h0001, 8'h00);
                push_access(1'b0, 16'h0001, 8'h00);
                push_access(1'b0, 16'hBFFF, 8'h00);
                push_access(1'b0, 16'hD800, 8'h00);
                push_access(1'b1, 16'h0001, 8'hFF);
                push_access(1'b0, 16'hD000, 8'h00);
                push_access(1'b1, 16'h0001, 8'h03);
                push_access(1'b0, 16'hDFFF, 8'h00);
                push_access(1'b0, 16'hA000, 8'h00);
                push_access(1'b1, 16'h0001, 8'h04);
                push_access(1'b0, 16'hD000, 8'h00);
                push_access(1'b1, 16'h0001, 8'h02);
                push_access(1'b0, 16'hF000, 8'h00);
                push_access(1'b1, 16'h0000, 8'h00);
                push_access(1'b0, 16'h0001, 8'hFF);
                push_access(1'b1, 16'h5555, 8'hAA);
                push_access(1'b0, 16'h0000, 8'hFF);
            end
            else
            begin
                repeat (RANDOM_PER_PHASE) queued_accesses.push_back(random_access());
            end
            drain();
        end

        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Driver: sends queued accesses in bursts separated by random gaps.
    always @(posedge clk)
    begin
        cpu_access_t nxt;
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
                awaited_decodes.push_back(decode_access(kind, address, write_data));
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (queued_accesses.size() != 0)
                begin
                    nxt = queued_accesses.pop_front();
                    in_valid <= 1'b1;
                    kind <= nxt.is_write;
                    address <= nxt.addr;
                    write_data <= nxt.wdata;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: stalls in changing modes and checks each result transaction.
    always @(posedge clk)
    begin
        result_t want;
        cycle_count++;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (awaited_decodes.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: target %0d read %h pins %h dir %h",
                                 target, port_read_data, port_pins_out, port_direction_out);
                end
                else
                begin
                    want = awaited_decodes.pop_front();
                    if (target !== want.target || port_read_data !== want.read_data ||
                        port_pins_out !== want.pins_out ||
                        port_direction_out !== want.direction_out)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"mismatch exp/act: target %0d/%0d read %h/%h ",
                                      "pins %h/%h dir %h/%h"},
                                     want.target, target, want.read_data, port_read_data,
                                     want.pins_out, port_pins_out,
                                     want.direction_out, port_direction_out);
                    end
                end
            end

            // Pick a new stall mode when the stall timer runs out.
            if (stall_timer == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_timer = $urandom_range(50, 300);
            end
            else
                stall_timer--;
            case (stall_mode)
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= (cycle_count % 5 < 2);
                3: out_stall <= ($urandom_range(0, 9) < 7);
                default: out_stall <= 1'b0;
            endcase
        end
    end

    // Watchdog: ends the run when work is outstanding but nothing moves.
    always @(posedge clk)
    begin
        if (rst_n && (queued_accesses.size() != 0 || in_valid || awaited_decodes.size() != 0)
            && !(in_valid && !in_stall) && !(out_valid && !out_stall))
            idle_cycles++;
        else
            idle_cycles = 0;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

endmodule
